// File: sv/fdr_pkg.sv
`timescale 1ns / 1ps

package fdr_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_W       = 11;
    localparam int COORD_W     = 10;
    localparam int PIXEL_W     = 32;
    localparam int TDATA_OUT_W = 48;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd768;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic first_frame;
        logic frame_end;
    } item_flags_t;

endpackage

// File: sv/fdr_fifo.sv
`timescale 1ns / 1ps

module fdr_fifo import fdr_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = FIFO_DEPTH,
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              wr_ready,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              rd_valid
);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != (PW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + (PW+1)'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/fdr_front.sv
`timescale 1ns / 1ps

module fdr_front import fdr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW     = $clog2(MAX_WIDTH),
    localparam int LW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int ITEM_W = PIXEL_W + CW + LW + AW + $bits(item_flags_t)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [CFG_W-1:0]   cfg_width,
    input  logic [CFG_W-1:0]   cfg_height,
    output logic [CW:0]        eff_width,
    output logic [LW:0]        eff_height,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIXEL_W-1:0] s_tdata,
    output logic               fifo_wr_en,
    output logic [ITEM_W-1:0]  fifo_wr_data,
    input  logic               fifo_wr_ready
);

    logic [CW-1:0] col_reg, col_next;
    logic [LW-1:0] line_reg, line_next;
    logic [AW-1:0] base_reg, base_next;
    logic          first_reg, first_next;
    logic [CW-1:0] w_last;
    logic [LW-1:0] h_last;
    logic [AW-1:0] addr;
    logic          accept;
    logic          line_end;
    item_flags_t   flags;

    always_comb begin
        if (cfg_width == '0) begin
            w_last = '0;
        end else if (32'(cfg_width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(cfg_width - CFG_W'(1));
        end
        if (cfg_height == '0) begin
            h_last = '0;
        end else if (32'(cfg_height) > MAX_HEIGHT) begin
            h_last = LW'(MAX_HEIGHT - 1);
        end else begin
            h_last = LW'(cfg_height - CFG_W'(1));
        end
    end

    assign eff_width        = (CW+1)'(w_last) + (CW+1)'(1);
    assign eff_height       = (LW+1)'(h_last) + (LW+1)'(1);
    assign s_tready         = fifo_wr_ready;
    assign accept           = s_tvalid && s_tready;
    assign addr             = base_reg + AW'(col_reg);
    assign line_end         = (col_reg >= w_last);
    assign flags.first_frame = first_reg;
    assign flags.frame_end  = line_end && (line_reg >= h_last);
    assign fifo_wr_en       = accept;
    assign fifo_wr_data     = {s_tdata, col_reg, line_reg, addr, flags};

    always_comb begin
        col_next   = col_reg;
        line_next  = line_reg;
        base_next  = base_reg;
        first_next = first_reg;
        if (accept) begin
            priority if (flags.frame_end) begin
                col_next   = '0;
                line_next  = '0;
                base_next  = '0;
                first_next = 1'b0;
            end else if (line_end) begin
                col_next  = '0;
                line_next = line_reg + LW'(1);
                base_next = base_reg + AW'(MAX_WIDTH);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            line_reg  <= '0;
            base_reg  <= '0;
            first_reg <= 1'b1;
        end else begin
            col_reg   <= col_next;
            line_reg  <= line_next;
            base_reg  <= base_next;
            first_reg <= first_next;
        end
    end

endmodule

// File: sv/fdr_back.sv
`timescale 1ns / 1ps

module fdr_back import fdr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW          = $clog2(MAX_WIDTH),
    localparam int LW          = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int AW          = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int ITEM_W      = PIXEL_W + CW + LW + AW + $bits(item_flags_t)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CW:0]            eff_width,
    input  logic [LW:0]            eff_height,
    input  logic [ITEM_W-1:0]      fifo_rd_data,
    input  logic                   fifo_rd_valid,
    output logic                   fifo_rd_en,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    localparam int PAD_W = TDATA_OUT_W - 1 - 4 * COORD_W;

    logic [PIXEL_W-1:0] store_mem [STORE_DEPTH];

    logic [PIXEL_W-1:0] in_pix;
    logic [CW-1:0]      in_col;
    logic [LW-1:0]      in_line;
    logic [AW-1:0]      in_addr;
    item_flags_t        in_flags;

    logic               s2_valid_reg;
    logic [PIXEL_W-1:0] s2_pix_reg;
    logic [PIXEL_W-1:0] prev_reg;
    logic [CW-1:0]      s2_col_reg;
    logic [LW-1:0]      s2_line_reg;
    item_flags_t        s2_flags_reg;

    logic [CW:0]        min_col_reg, min_col_next;
    logic [CW-1:0]      max_col_reg, max_col_next;
    logic [LW:0]        min_line_reg, min_line_next;
    logic [LW-1:0]      max_line_reg, max_line_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic diff, changed, emit, stall, go, issue;
    logic [COORD_W-1:0] left_c, top_c, right_c, bottom_c;

    assign {in_pix, in_col, in_line, in_addr, in_flags} = fifo_rd_data;

    assign emit  = s2_valid_reg && s2_flags_reg.frame_end && !s2_flags_reg.first_frame;
    assign stall = emit && m_tvalid_reg && !m_tready;
    assign go    = s2_valid_reg && !stall;
    assign issue = fifo_rd_valid && !stall;

    assign fifo_rd_en = issue;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (issue) begin
            prev_reg           <= store_mem[in_addr];
            store_mem[in_addr] <= in_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s2_pix_reg   <= in_pix;
            s2_col_reg   <= in_col;
            s2_line_reg  <= in_line;
            s2_flags_reg <= in_flags;
        end
    end

    // The box minima start from the frame size in force at the previous frame end.
    always_comb begin
        diff          = !s2_flags_reg.first_frame && (prev_reg != s2_pix_reg);
        min_col_next  = min_col_reg;
        max_col_next  = max_col_reg;
        min_line_next = min_line_reg;
        max_line_next = max_line_reg;
        if (diff) begin
            if ((CW+1)'(s2_col_reg) < min_col_reg) begin
                min_col_next = (CW+1)'(s2_col_reg);
            end
            if (s2_col_reg > max_col_reg) begin
                max_col_next = s2_col_reg;
            end
            if ((LW+1)'(s2_line_reg) < min_line_reg) begin
                min_line_next = (LW+1)'(s2_line_reg);
            end
            if (s2_line_reg > max_line_reg) begin
                max_line_next = s2_line_reg;
            end
        end

        changed  = (min_col_next <= (CW+1)'(max_col_next));
        left_c   = changed ? COORD_W'(min_col_next)  : '0;
        top_c    = changed ? COORD_W'(min_line_next) : '0;
        right_c  = changed ? COORD_W'(max_col_next)  : '0;
        bottom_c = changed ? COORD_W'(max_line_next) : '0;

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (go && emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{PAD_W{1'b0}}, bottom_c, right_c, top_c, left_c, changed};
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            min_col_reg  <= eff_width;
            min_line_reg <= eff_height;
            max_col_reg  <= '0;
            max_line_reg <= '0;
        end else begin
            if (!stall) begin
                s2_valid_reg <= issue;
            end
            if (go) begin
                if (s2_flags_reg.frame_end) begin
                    min_col_reg  <= eff_width;
                    min_line_reg <= eff_height;
                    max_col_reg  <= '0;
                    max_line_reg <= '0;
                end else begin
                    min_col_reg  <= min_col_next;
                    min_line_reg <= min_line_next;
                    max_col_reg  <= max_col_next;
                    max_line_reg <= max_line_next;
                end
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: sv/frame_dirty_rectangle_top.sv
`timescale 1ns / 1ps

// Frame change detector with dirty rectangle output.
// The s_ stream carries 32-bit pixels in raster order, one per transaction.
// Each pixel is compared with the same position of the previous frame held in
// an internal frame store, and then replaces it. After the last pixel of every
// frame but the first, one transaction on the m_ stream gives the change flag
// and the inclusive bounding box of changed pixels, or zeros if none changed.
// The frame size is set over the APB port: frame_width at address 0 and
// frame_height at address 4; write it only while no frame is in progress.
// One pixel is taken per cycle while s_tready is high. A pixel passes a
// four-entry queue, then a store read-and-write cycle, then the compare
// stage, and the result is then registered in the output register.
// The rate is set by the single frame store port, used once per pixel.
// When the receiver stalls, the result waits in the output register and
// pixels keep flowing until a second result would be produced; then the
// queue fills and s_tready drops. Reset clears counters, the queue and the
// output and restores 1024 by 768; the store needs no clearing, because the
// first frame after reset is only stored.

module frame_dirty_rectangle_top import fdr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] pixel_value
    input  logic [PIXEL_W-1:0]     s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] frame_changed, [10:1] left_column, [20:11] top_line,
    // [30:21] right_column, [40:31] bottom_line, [47:41] zero
    output logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int LW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int ITEM_W = PIXEL_W + CW + LW + AW + $bits(item_flags_t);

    logic [CFG_W-1:0]  width_reg, width_next;
    logic [CFG_W-1:0]  height_reg, height_next;
    logic              cfg_wr;
    logic              reg_sel;
    logic [CW:0]       eff_width;
    logic [LW:0]       eff_height;
    logic              fifo_wr_en, fifo_wr_ready;
    logic [ITEM_W-1:0] fifo_wr_data;
    logic              fifo_rd_en, fifo_rd_valid;
    logic [ITEM_W-1:0] fifo_rd_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_FRAME_WIDTH;
            height_reg <= RESET_FRAME_HEIGHT;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    fdr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_width     (width_reg),
        .cfg_height    (height_reg),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .fifo_wr_en    (fifo_wr_en),
        .fifo_wr_data  (fifo_wr_data),
        .fifo_wr_ready (fifo_wr_ready)
    );

    fdr_fifo #(
        .DATA_W (ITEM_W),
        .DEPTH  (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (fifo_wr_en),
        .wr_data  (fifo_wr_data),
        .wr_ready (fifo_wr_ready),
        .rd_en    (fifo_rd_en),
        .rd_data  (fifo_rd_data),
        .rd_valid (fifo_rd_valid)
    );

    fdr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .fifo_rd_data  (fifo_rd_data),
        .fifo_rd_valid (fifo_rd_valid),
        .fifo_rd_en    (fifo_rd_en),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
